// ===== rtl/u8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dec_pkg
// shared types and constants of the utf-8 byte stream decoder
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
    localparam logic [7:0]      ASCII_TOP = 8'h80;
    localparam logic [7:0]      LEAD2_MIN = 8'hC0;
    localparam logic [7:0]      LEAD3_MIN = 8'hE0;
    localparam logic [7:0]      LEAD4_MIN = 8'hF0;
    localparam logic [1:0]      CONT_TAG  = 2'b10;

    // one queue record: up to two results caused by one input byte
    typedef struct packed {
        logic            two;
        logic [CP_W-1:0] cp0;
        logic            bad0;
        logic [CP_W-1:0] cp1;
        logic            bad1;
        logic            last;
    } u8dec_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } u8dec_qstat_t;

endpackage

// ===== rtl/utf8_byte_stream_decoder_unit.sv =====
// each result is held in the queue and then in the output register
// throughput: one byte per cycle while the queue is not full (s_tready low
//   when full); a two-result record is unpacked one result per output load
// bytes that only open or extend a sequence yield no result at all
// reset: rst_n clears the open sequence, the queue and the output register
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// utf-8 byte stream to code point decoder, front and back joined by a queue
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_tuser,   // [0] malformed, [1] run_end
    output logic        m_tlast    // string_done
);
    import u8dec_pkg::*;

    logic         push;
    logic         pop;
    u8dec_rec_t   push_rec;
    u8dec_rec_t   head_rec;
    u8dec_qstat_t q_stat;

    u8dec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_rec (push_rec)
    );

    u8dec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    u8dec_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_rec (head_rec),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/u8dec_front.sv =====
// ----------------------------------------------------------------------------
// u8dec_front
// takes bytes, tracks the open sequence and builds result records
// ----------------------------------------------------------------------------
module u8dec_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,
    input  u8dec_pkg::u8dec_qstat_t q_stat,
    output logic                push,
    output u8dec_pkg::u8dec_rec_t push_rec
);
    import u8dec_pkg::*;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] cp;
        logic            bad;
        logic [1:0]      pend;
        logic [CP_W-1:0] part;
    } lead_t;

    logic [1:0]      pend_reg, pend_next;
    logic [CP_W-1:0] part_reg, part_next;
    logic            accept;
    logic            emit;
    lead_t           lead;
    logic [1:0]      extra;
    logic [1:0]      pend_dec;
    logic [CP_W-1:0] part_shift;
    u8dec_rec_t      rec;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // decode of the byte as a lead with no sequence open
    always_comb
    begin
        if (s_tdata >= LEAD4_MIN)
            extra = 2'd3;
        else if (s_tdata >= LEAD3_MIN)
            extra = 2'd2;
        else
            extra = 2'd1;

        lead.emit = 1'b0;
        lead.cp   = REPL_CP;
        lead.bad  = 1'b0;
        lead.pend = 2'd0;
        lead.part = '0;
        if (s_tdata < ASCII_TOP)
        begin
            lead.emit = 1'b1;
            lead.cp   = {{(CP_W-8){1'b0}}, s_tdata};
        end
        else if (s_tdata < LEAD2_MIN)
        begin
            lead.emit = 1'b1;
            lead.bad  = 1'b1;
        end
        else if (s_tlast)
        begin
            // string ends right after a lead
            lead.emit = 1'b1;
            lead.bad  = 1'b1;
        end
        else
        begin
            lead.pend = extra;
            unique case (extra)
                2'd1:    lead.part = {{(CP_W-5){1'b0}}, s_tdata[4:0]};
                2'd2:    lead.part = {{(CP_W-4){1'b0}}, s_tdata[3:0]};
                default: lead.part = {{(CP_W-3){1'b0}}, s_tdata[2:0]};
            endcase
        end
    end

    assign pend_dec   = 2'(pend_reg - 2'd1);
    assign part_shift = {part_reg[CP_W-7:0], s_tdata[5:0]};

    always_comb
    begin
        pend_next = pend_reg;
        part_next = part_reg;
        emit      = 1'b0;
        rec.two   = 1'b0;
        rec.cp0   = REPL_CP;
        rec.bad0  = 1'b0;
        rec.cp1   = lead.cp;
        rec.bad1  = lead.bad;
        rec.last  = s_tlast;
        if (pend_reg == 2'd0)
        begin
            emit      = lead.emit;
            rec.cp0   = lead.cp;
            rec.bad0  = lead.bad;
            pend_next = lead.pend;
            part_next = lead.part;
        end
        else if (s_tdata[7:6] == CONT_TAG)
        begin
            if (pend_dec == 2'd0)
            begin
                emit      = 1'b1;
                rec.cp0   = part_shift;
                pend_next = 2'd0;
                part_next = '0;
            end
            else if (s_tlast)
            begin
                emit      = 1'b1;
                rec.bad0  = 1'b1;
                pend_next = 2'd0;
                part_next = '0;
            end
            else
            begin
                pend_next = pend_dec;
                part_next = part_shift;
            end
        end
        else
        begin
            // broken sequence: replacement, then the byte again as a lead
            emit      = 1'b1;
            rec.bad0  = 1'b1;
            rec.two   = lead.emit;
            pend_next = lead.pend;
            part_next = lead.part;
        end
    end

    assign push     = accept && emit;
    assign push_rec = rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            part_reg <= part_next;
        end
    end

endmodule

// ===== rtl/u8dec_queue.sv =====
// ----------------------------------------------------------------------------
// u8dec_queue
// two-entry record queue between the byte front and the result back
// ----------------------------------------------------------------------------
module u8dec_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  u8dec_pkg::u8dec_rec_t   push_rec,
    input  logic                    pop,
    output u8dec_pkg::u8dec_rec_t   head_rec,
    output u8dec_pkg::u8dec_qstat_t q_stat
);
    import u8dec_pkg::*;

    u8dec_rec_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign head_rec     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("record pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("record popped from an empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == 2'd0) || (count_reg == 2'd2)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/u8dec_back.sv =====
// ----------------------------------------------------------------------------
// u8dec_back
// unpacks records into single results behind an output register
// ----------------------------------------------------------------------------
module u8dec_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  u8dec_pkg::u8dec_rec_t   head_rec,
    input  u8dec_pkg::u8dec_qstat_t q_stat,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]              m_tuser,   // [0] malformed, [1] run_end
    output logic                    m_tlast    // string_done
);
    import u8dec_pkg::*;

    logic            valid_reg;
    logic            sub_reg, sub_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            bad_reg, bad_next;
    logic            run_end_reg, run_end_next;
    logic            done_reg, done_next;
    logic            load;

    assign load = !q_stat.empty && (!valid_reg || m_tready);

    always_comb
    begin
        sub_next     = sub_reg;
        pop          = 1'b0;
        cp_next      = sub_reg ? head_rec.cp1 : head_rec.cp0;
        bad_next     = sub_reg ? head_rec.bad1 : head_rec.bad0;
        run_end_next = 1'b1;
        done_next    = head_rec.last;
        if (load)
        begin
            if (head_rec.two && !sub_reg)
            begin
                // first of two results from the same byte
                sub_next     = 1'b1;
                run_end_next = 1'b0;
                done_next    = 1'b0;
            end
            else
            begin
                sub_next = 1'b0;
                pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
            if (load)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg      <= cp_next;
            bad_reg     <= bad_next;
            run_end_reg <= run_end_next;
            done_reg    <= done_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(24-CP_W){1'b0}}, cp_reg};
    assign m_tuser  = {run_end_reg, bad_reg};
    assign m_tlast  = done_reg;

endmodule

// ===== test/utf8_cp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_cp_checker
// watches both streams of the utf-8 decoder, predicts the code points that
// each accepted byte must produce and compares every result in order
// ----------------------------------------------------------------------------
module utf8_cp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // is_last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    input  logic [1:0]  m_tuser,   // [0] malformed, [1] run_end
    input  logic        m_tlast,   // string_done
    output int          mismatches,
    output int          pending,
    output int          cp_count,
    output int          repl_count
);
    import u8dec_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            bad;
        logic            done;
        logic            run_end;
    } cp_result_t;

    cp_result_t      cp_expected_q[$];
    logic [1:0]      cont_left;
    logic [CP_W-1:0] cp_accum;

    function automatic cp_result_t repl_result();
        cp_result_t r;
        r.cp      = REPL_CP;
        r.bad     = 1'b1;
        r.done    = 1'b0;
        r.run_end = 1'b0;
        return r;
    endfunction

    // byte seen with no sequence open; returns 1 when it yields a result
    function automatic logic lead_result(input logic [7:0] b, input logic last,
                                         output cp_result_t r);
        logic [1:0] extra;
        r = repl_result();
        if (b < ASCII_TOP)
        begin
            r.cp  = CP_W'(b);
            r.bad = 1'b0;
            return 1'b1;
        end
        if (b < LEAD2_MIN)
            return 1'b1;
        extra = (b >= LEAD4_MIN) ? 2'd3 : (b >= LEAD3_MIN) ? 2'd2 : 2'd1;
        if (last)
        begin
            cont_left = 2'd0;
            cp_accum  = '0;
            return 1'b1;
        end
        cont_left = extra;
        cp_accum  = CP_W'(b & (8'h3F >> extra));
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic last);
        cp_result_t outs[2];
        int         n;
        n = 0;
        if (cont_left == 2'd0)
        begin
            if (lead_result(b, last, outs[0]))
                n = 1;
        end
        else if (b[7:6] == CONT_TAG)
        begin
            cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
            begin
                outs[0]     = repl_result();
                outs[0].cp  = cp_accum;
                outs[0].bad = 1'b0;
                cp_accum    = '0;
                n = 1;
            end
            else if (last)
            begin
                cont_left = 2'd0;
                cp_accum  = '0;
                outs[0]   = repl_result();
                n = 1;
            end
        end
        else
        begin
            // broken sequence: replacement, then the byte starts over as a lead
            cont_left = 2'd0;
            cp_accum  = '0;
            outs[0]   = repl_result();
            n = 1;
            if (lead_result(b, last, outs[1]))
                n = 2;
        end
        if (n > 0)
        begin
            outs[n-1].run_end = 1'b1;
            outs[n-1].done    = last;
        end
        for (int i = 0; i < n; i++)
            cp_expected_q.insert(cp_expected_q.size(), outs[i]);
    endtask

    always @(posedge clk)
    begin
        cp_result_t exp_r;
        if (!rst_n)
        begin
            cp_expected_q.delete();
            cont_left  = 2'd0;
            cp_accum   = '0;
            mismatches = 0;
            cp_count   = 0;
            repl_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (cp_expected_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, got cp=%h bad=%b done=%b end=%b",
                             $time, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
                end
                else
                begin
                    exp_r = cp_expected_q.pop_front();
                    cp_count++;
                    if (exp_r.bad)
                        repl_count++;
                    if (m_tdata[CP_W-1:0] !== exp_r.cp || m_tdata[23:CP_W] !== '0 ||
                        m_tuser[0] !== exp_r.bad || m_tuser[1] !== exp_r.run_end ||
                        m_tlast !== exp_r.done)
                    begin
                        mismatches++;
                        $display("%0t: expected cp=%h b=%b d=%b e=%b got cp=%h b=%b d=%b e=%b",
                                 $time, exp_r.cp, exp_r.bad, exp_r.done, exp_r.run_end,
                                 m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
                    end
                end
            end
        end
        pending = cp_expected_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives byte strings into the utf-8 decoder, well-formed and broken, with
// random gaps and stalls on both streams; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum int {
        ANY_BYTE,
        STRAY_CONT,
        CUT_SEQ
    } noise_kind_e;

    localparam int BYTE_TARGET = 1050;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 24;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatches;
    int pending;
    int cp_count;
    int repl_count;

    logic src_idle_on;
    logic sink_idle_on;
    logic stall_ask;
    logic stall_seen;
    int   hold_left;
    int   bytes_sent;
    int   strings_sent;

    logic [8:0] directed_bytes[] = '{
        9'h000, 9'h07F, 9'h141,                 // ascii extremes
        9'h080, 9'h0BF,                         // stray continuation bytes
        9'h0C2, 9'h0A9, 9'h0DF, 9'h0BF,         // two-byte
        9'h0E2, 9'h082, 9'h0AC,                 // three-byte
        9'h0F0, 9'h09F, 9'h098, 9'h080,         // four-byte
        9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF,         // widest payload
        9'h0E2, 9'h041,                         // broken by ascii
        9'h0C2, 9'h1E2,                         // broken by a last lead: two results
        9'h0E2, 9'h182,                         // string ends mid-sequence
        9'h1F0                                  // lone lead as last byte
    };

    utf8_byte_stream_decoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_cp_checker cp_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending),
        .cp_count   (cp_count),
        .repl_count (repl_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // result side: random back-pressure plus one long hold-off on request
    initial
    begin
        m_tready   = 1'b0;
        stall_seen = 1'b0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else if (stall_ask != stall_seen)
            begin
                stall_seen = stall_ask;
                hold_left  = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (sink_idle_on)
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic logic [7:0] rand_lead(input int len);
        case (len)
            1:       return 8'($urandom_range(0, 127));
            2:       return 8'hC0 | 8'($urandom_range(0, 31));
            3:       return 8'hE0 | 8'($urandom_range(0, 15));
            default: return 8'hF0 | 8'($urandom_range(0, 15));
        endcase
    endfunction

    // mostly well-formed characters with random payload, some noise
    task automatic send_string(input int n_chars);
        logic [7:0] str_q[$];
        int         len;
        for (int c = 0; c < n_chars; c++)
        begin
            if ($urandom_range(99) < 80)
            begin
                len = $urandom_range(1, 4);
                str_q.insert(str_q.size(), rand_lead(len));
                repeat (len - 1)
                    str_q.insert(str_q.size(), 8'h80 | 8'($urandom_range(0, 63)));
            end
            else
            begin
                case (noise_kind_e'($urandom_range(0, 2)))
                    ANY_BYTE:
                        str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
                    STRAY_CONT:
                        str_q.insert(str_q.size(), 8'h80 | 8'($urandom_range(0, 63)));
                    CUT_SEQ:
                    begin
                        len = $urandom_range(2, 4);
                        str_q.insert(str_q.size(), rand_lead(len));
                        repeat ($urandom_range(0, len - 2))
                            str_q.insert(str_q.size(), 8'h80 | 8'($urandom_range(0, 63)));
                    end
                    default:
                        str_q.insert(str_q.size(), 8'h00);
                endcase
            end
        end
        foreach (str_q[i])
            send_byte(str_q[i], i == str_q.size() - 1);
        strings_sent++;
    endtask

    initial
    begin
        logic held;
        logic paused;
        held         = 1'b0;
        paused       = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        stall_ask    = 1'b0;
        bytes_sent   = 0;
        strings_sent = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        wait_drained();

        while (bytes_sent < BYTE_TARGET)
        begin
            if (!held && bytes_sent >= 300)
            begin
                // receiver holds off while the sender keeps offering bytes
                held      = 1'b1;
                stall_ask = ~stall_ask;
            end
            if (!paused && bytes_sent >= 600)
            begin
                paused = 1'b1;
                wait_drained();
            end
            src_idle_on  = !(bytes_sent >= 700 && bytes_sent < 900);
            sink_idle_on = src_idle_on;
            send_string($urandom_range(1, 10));
        end
        s_tvalid <= 1'b0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("tb_top: %0d bytes in %0d strings, %0d code points compared,",
                 bytes_sent, strings_sent, cp_count);
        $display("tb_top: %0d of them replacements, %0d mismatching", repl_count, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: timeout with %0d results outstanding", pending);
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== utf8_byte_stream_decoder_unit.f =====
rtl/u8dec_pkg.sv
rtl/u8dec_front.sv
rtl/u8dec_queue.sv
rtl/u8dec_back.sv
rtl/utf8_byte_stream_decoder_unit.sv
test/utf8_cp_checker.sv
test/tb_top.sv
